[design/bcc_pkg.sv]
// Shared types, widths and helpers for the barometer calibration compensation block.
// No dependencies; used by bcc_horner_step and the top level.
package bcc_pkg;

  localparam int FRAC      = 30;   // fractional bits of the Q30 datapath
  localparam int ACC_W     = 56;   // Q30 accumulator width, 26 integer bits
  localparam int SC_W      = 32;   // scaled sample width, signed Q1.30
  localparam int RECIP_Q30 = 137;  // round(2^30 / 7864320)
  localparam int COEF_W    = 20;   // widest calibration coefficient

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_0_7   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_8_15  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_16_20 = 2'd2;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [SC_W-1:0]  sc_t;

  typedef struct packed {
    logic signed [23:0] raw_temperature;
    logic signed [23:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_q8;
    logic        [21:0] pressure_q4;
    logic               in_range;
  } out_t;

  // values that ride along the Horner pipeline
  typedef struct packed {
    sc_t  tsc;
    sc_t  psc;
    acc_t t;
  } side_t;

  // one Horner lane: acc = add + floor(mul * val / 2^30)
  typedef struct packed {
    sc_t  mul;
    acc_t val;
    acc_t add;
  } lane_t;

  function automatic acc_t to_q30(input logic signed [COEF_W-1:0] c);
    to_q30 = {{(ACC_W-FRAC-COEF_W){c[COEF_W-1]}}, c, {FRAC{1'b0}}};
  endfunction

endpackage

[design/bcc_horner_step.sv]
// One two-lane Horner step: split multiply stage, then fold-and-add stage.
// Depends on bcc_pkg.
module bcc_horner_step
  import bcc_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_a,
  input  lane_t lane_b,
  input  side_t side_in,
  output acc_t  acc_a,
  output acc_t  acc_b,
  output side_t side_out
);

  localparam int HI_W  = ACC_W - FRAC;
  localparam int PHI_W = SC_W + HI_W;
  localparam int PLO_W = SC_W + FRAC + 1;

  logic signed [PHI_W-1:0] hi_a_nxt, hi_b_nxt, hi_a_r, hi_b_r;
  logic signed [PLO_W-1:0] lo_a_nxt, lo_b_nxt, lo_a_r, lo_b_r;
  acc_t  add_a_r, add_b_r, acc_a_nxt, acc_b_nxt, acc_a_r, acc_b_r;
  side_t side1_r, side2_r;
  logic signed [PHI_W-1:0] sum_a, sum_b;

  // split val into integer and fraction parts, each product fits 32x32
  always_comb begin
    hi_a_nxt = lane_a.mul * $signed(lane_a.val[ACC_W-1:FRAC]);
    hi_b_nxt = lane_b.mul * $signed(lane_b.val[ACC_W-1:FRAC]);
    lo_a_nxt = lane_a.mul * $signed({1'b0, lane_a.val[FRAC-1:0]});
    lo_b_nxt = lane_b.mul * $signed({1'b0, lane_b.val[FRAC-1:0]});
  end

  always_comb begin
    sum_a = hi_a_r + PHI_W'(lo_a_r >>> FRAC) + PHI_W'(add_a_r);
    sum_b = hi_b_r + PHI_W'(lo_b_r >>> FRAC) + PHI_W'(add_b_r);
    acc_a_nxt = sum_a[ACC_W-1:0];
    acc_b_nxt = sum_b[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_a_r  <= hi_a_nxt;
      hi_b_r  <= hi_b_nxt;
      lo_a_r  <= lo_a_nxt;
      lo_b_r  <= lo_b_nxt;
      add_a_r <= lane_a.add;
      add_b_r <= lane_b.add;
      side1_r <= side_in;
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      side2_r <= side1_r;
    end
  end

  assign acc_a    = acc_a_r;
  assign acc_b    = acc_b_r;
  assign side_out = side2_r;

endmodule

[design/barometer_calibration_compensation_unit.sv]
// Top level of the barometer calibration compensation block.
// Depends on bcc_pkg and bcc_horner_step.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request per sample:
//   signed 24-bit raw temperature and raw pressure. Result channel
//   out_valid/out_ready/out_data returns, in order, the temperature in
//   1/256 C, the pressure in 1/16 Pa (both rounded and saturated) and an
//   in-range flag. Configuration: write cfg_data to register cfg_index on
//   any cycle with cfg_we high; index 0..2 hold the 21 calibration bytes,
//   other indices are dropped. Write calibration only while idle.
//   Throughput: one request per cycle while the result channel does not
//   stall. The pipeline depth comes from four two-stage Horner steps (multiply,
//   then fold and add), a scaling stage, a final sum and the round/clamp
//   output register.
//   Reset: rst_n (synchronous, active low) clears the pipeline valid bits
//   and the calibration registers to zero.
//   Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; bubbles advance as soon as the result leaves.
module barometer_calibration_compensation_unit
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int LAT  = 11;
  localparam int TQ_W = ACC_W - 22;
  localparam int PQ_W = ACC_W - 26;
  localparam logic signed [TQ_W-1:0] T_MIN = -TQ_W'(32768);
  localparam logic signed [TQ_W-1:0] T_MAX = TQ_W'(32767);
  localparam logic signed [TQ_W-1:0] T_LO  = -TQ_W'(40 * 256);
  localparam logic signed [TQ_W-1:0] T_HI  = TQ_W'(85 * 256);
  localparam logic signed [PQ_W-1:0] P_MAX = PQ_W'(4194303);
  localparam logic signed [PQ_W-1:0] P_LO  = PQ_W'(30000 * 16);
  localparam logic signed [PQ_W-1:0] P_HI  = PQ_W'(110000 * 16);

  // calibration registers
  logic [63:0] cal0_r, cal1_r;
  logic [39:0] cal2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_0_7:   cal0_r <= cfg_data;
        CFG_CAL_8_15:  cal1_r <= cfg_data;
        CFG_CAL_16_20: cal2_r <= cfg_data[39:0];
        default:       ;
      endcase
    end
  end

  // unpack coefficients, sign-extended to the common width
  logic signed [COEF_W-1:0] c0, c1, c00, c10, c01, c11, c20, c21, c30, c31, c40;
  always_comb begin
    c0  = COEF_W'($signed(cal0_r[63:52]));
    c1  = COEF_W'($signed(cal0_r[51:40]));
    c00 = $signed(cal0_r[39:20]);
    c10 = $signed(cal0_r[19:0]);
    c01 = COEF_W'($signed(cal1_r[63:48]));
    c11 = COEF_W'($signed(cal1_r[47:32]));
    c20 = COEF_W'($signed(cal1_r[31:16]));
    c21 = COEF_W'($signed(cal1_r[15:0]));
    c30 = COEF_W'($signed(cal2_r[39:24]));
    c31 = COEF_W'($signed(cal2_r[23:12]));
    c40 = COEF_W'($signed(cal2_r[11:0]));
  end

  // advance everything unless a finished result is held back
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // scale raw samples to Q1.30
  sc_t tsc_r, psc_r, tsc_nxt, psc_nxt;
  always_comb begin
    tsc_nxt = SC_W'(in_data.raw_temperature * RECIP_Q30);
    psc_nxt = SC_W'(in_data.raw_pressure * RECIP_Q30);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tsc_r <= tsc_nxt;
      psc_r <= psc_nxt;
    end
  end

  // four Horner steps; lane a is the pure pressure polynomial, lane b the
  // temperature cross term
  acc_t  pa1, pb1, pa2, pb2, pa3, pb3, pa4, pb4;
  side_t side1_in, side1, side2_in, side2, side3, side4;
  lane_t la1, lb1, la2, lb2, la3, lb3, la4, lb4;
  logic signed [SC_W+COEF_W-1:0] t_prod;

  always_comb begin
    side1_in = '{tsc: tsc_r, psc: psc_r, t: '0};
    la1 = '{mul: psc_r, val: to_q30(c40), add: to_q30(c30)};
    lb1 = '{mul: psc_r, val: to_q30(c31), add: to_q30(c21)};
  end

  bcc_horner_step u_step1 (
    .clk(clk), .en(adv), .lane_a(la1), .lane_b(lb1), .side_in(side1_in),
    .acc_a(pa1), .acc_b(pb1), .side_out(side1)
  );

  // temperature: c0/2 + c1*Tsc, exact
  always_comb begin
    t_prod     = side1.tsc * c1;
    side2_in   = side1;
    side2_in.t = (to_q30(c0) >>> 1) + ACC_W'(t_prod);
    la2 = '{mul: side1.psc, val: pa1, add: to_q30(c20)};
    lb2 = '{mul: side1.psc, val: pb1, add: to_q30(c11)};
  end

  bcc_horner_step u_step2 (
    .clk(clk), .en(adv), .lane_a(la2), .lane_b(lb2), .side_in(side2_in),
    .acc_a(pa2), .acc_b(pb2), .side_out(side2)
  );

  always_comb begin
    la3 = '{mul: side2.psc, val: pa2, add: to_q30(c10)};
    lb3 = '{mul: side2.psc, val: pb2, add: to_q30(c01)};
  end

  bcc_horner_step u_step3 (
    .clk(clk), .en(adv), .lane_a(la3), .lane_b(lb3), .side_in(side2),
    .acc_a(pa3), .acc_b(pb3), .side_out(side3)
  );

  always_comb begin
    la4 = '{mul: side3.psc, val: pa3, add: '0};
    lb4 = '{mul: side3.tsc, val: pb3, add: '0};
  end

  bcc_horner_step u_step4 (
    .clk(clk), .en(adv), .lane_a(la4), .lane_b(lb4), .side_in(side3),
    .acc_a(pa4), .acc_b(pb4), .side_out(side4)
  );

  // final pressure sum
  acc_t p_r, t_r, p_nxt;
  assign p_nxt = to_q30(c00) + pa4 + pb4;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
      t_r <= side4.t;
    end
  end

  // round half up, range check, saturate
  acc_t t_rnd, p_rnd;
  logic signed [TQ_W-1:0] tq;
  logic signed [PQ_W-1:0] pq;
  out_t out_nxt, out_r;

  always_comb begin
    t_rnd = t_r + ACC_W'(1 << 21);
    p_rnd = p_r + ACC_W'(1 << 25);
    tq    = t_rnd[ACC_W-1:22];
    pq    = p_rnd[ACC_W-1:26];
    out_nxt.in_range = (tq >= T_LO) && (tq <= T_HI) && (pq >= P_LO) && (pq <= P_HI);
    if (tq < T_MIN) begin
      out_nxt.temperature_q8 = 16'sh8000;
    end else if (tq > T_MAX) begin
      out_nxt.temperature_q8 = 16'sh7fff;
    end else begin
      out_nxt.temperature_q8 = tq[15:0];
    end
    if (pq < 0) begin
      out_nxt.pressure_q4 = '0;
    end else if (pq > P_MAX) begin
      out_nxt.pressure_q4 = '1;
    end else begin
      out_nxt.pressure_q4 = pq[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // in-range results carry in-range pressure
  a_range_p: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_range |->
      out_data.pressure_q4 >= 22'd480000 && out_data.pressure_q4 <= 22'd1760000)
    else $error("in_range set with pressure out of range");

  // in-range results carry in-range temperature
  a_range_t: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_range |->
      out_data.temperature_q8 >= -16'sd10240 && out_data.temperature_q8 <= 16'sd21760)
    else $error("in_range set with temperature out of range");

endmodule

[bench/tb_top.sv]
// Self-checking bench for barometer_calibration_compensation_unit: random and directed
// samples under several calibration sets, checked against an in-bench fixed-point predictor.
// Depends on bcc_pkg and the block's RTL.
module tb_top;
  import bcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAL_0_7;
  logic [63:0] cfg_data = '0;

  localparam int LATENCY = 11;
  // The index above the implemented registers; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  barometer_calibration_compensation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the calibration registers.
  logic [63:0] cal_lo, cal_mid;
  logic [39:0] cal_hi;

  in_t  sample_queue[$];
  out_t compensated_queue[$];
  int   mismatch_count = 0;
  int   recv_holdoff = 0;    // long receiver stall, counted in the monitor
  bit   send_drain = 1'b0;   // sender pauses until all results are back

  // floor(a*b / 2^30) with exact wide arithmetic.
  function automatic longint mul_q30(longint a, longint b);
    logic signed [127:0] prod;
    prod = 128'(signed'(a)) * 128'(signed'(b));
    return longint'(prod >>> 30);
  endfunction

  function automatic out_t compensate(in_t s);
    longint c0, c1, c00, c10, c01, c11, c20, c21, c30, c31, c40;
    longint tsc, psc, t, pa, pb, p, tq, pq, one;
    out_t r;
    one = 64'sd1 <<< 30;
    c0  = longint'(signed'(cal_lo[63:52]));
    c1  = longint'(signed'(cal_lo[51:40]));
    c00 = longint'(signed'(cal_lo[39:20]));
    c10 = longint'(signed'(cal_lo[19:0]));
    c01 = longint'(signed'(cal_mid[63:48]));
    c11 = longint'(signed'(cal_mid[47:32]));
    c20 = longint'(signed'(cal_mid[31:16]));
    c21 = longint'(signed'(cal_mid[15:0]));
    c30 = longint'(signed'(cal_hi[39:24]));
    c31 = longint'(signed'(cal_hi[23:12]));
    c40 = longint'(signed'(cal_hi[11:0]));
    tsc = longint'(s.raw_temperature) * RECIP_Q30;
    psc = longint'(s.raw_pressure) * RECIP_Q30;
    t = c0 * (one / 2) + mul_q30(tsc, c1 * one);
    pa = c40 * one;
    pa = c30 * one + mul_q30(psc, pa);
    pa = c20 * one + mul_q30(psc, pa);
    pa = c10 * one + mul_q30(psc, pa);
    pa = mul_q30(psc, pa);
    pb = c31 * one;
    pb = c21 * one + mul_q30(psc, pb);
    pb = c11 * one + mul_q30(psc, pb);
    pb = c01 * one + mul_q30(psc, pb);
    pb = mul_q30(tsc, pb);
    p = c00 * one + pa + pb;
    tq = (t + (64'sd1 <<< 21)) >>> 22;
    pq = (p + (64'sd1 <<< 25)) >>> 26;
    r.in_range = (tq >= -40 * 256) && (tq <= 85 * 256) &&
                 (pq >= 30000 * 16) && (pq <= 110000 * 16);
    r.temperature_q8 = tq < -32768 ? 16'sh8000 : (tq > 32767 ? 16'sh7FFF : 16'(tq));
    r.pressure_q4 = pq < 0 ? 22'd0 : (pq > 4194303 ? 22'h3FFFFF : 22'(pq));
    return r;
  endfunction

  // Driver: present queued requests, random gap before each one.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        compensated_queue.push_back(compensate(in_data));
        send_gap <= $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
        if (send_gap == 0 && sample_queue.size() > 0 && !send_drain &&
            $urandom_range(0, 3) == 0) begin
          // back-to-back: keep valid high with the next request
          in_data <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (sample_queue.size() > 0 && !send_drain) begin
          in_data  <= sample_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each accepted result, random ready stalls.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (compensated_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_t exp_r;
          exp_r = compensated_queue.pop_front();
          if (exp_r.temperature_q8 !== out_data.temperature_q8 ||
              exp_r.pressure_q4 !== out_data.pressure_q4 ||
              exp_r.in_range !== out_data.in_range) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp t=%0d p=%0d ok=%0b got t=%0d p=%0d ok=%0b",
                       exp_r.temperature_q8, exp_r.pressure_q4, exp_r.in_range,
                       out_data.temperature_q8, out_data.pressure_q4, out_data.in_range);
          end
        end
      end
      if (recv_holdoff > 0) begin
        recv_holdoff <= recv_holdoff - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        recv_gap <= $urandom_range(0, 10) * ($urandom_range(0, 2) == 0);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (sample_queue.size() > 0 || in_valid || compensated_queue.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Raise the write enable with index and data, then drop it and update the shadow copy.
  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAL_0_7) cal_lo = val;
    else if (idx == CFG_CAL_8_15) cal_mid = val;
    else if (idx == CFG_CAL_16_20) cal_hi = val[39:0];
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Typical-looking sensor coefficients, moderate magnitudes.
  task automatic load_typical();
    write_cal(CFG_CAL_0_7, {12'sd200, -12'sd270, 20'sd80000, -20'sd50000});
    write_cal(CFG_CAL_8_15, {-16'sd2800, 16'sd1200, -16'sd8000, 16'sd20});
    write_cal(CFG_CAL_16_20, {24'hFFFFFF, 16'sd100, 12'sd5, -12'sd3});
  endtask

  function automatic in_t rand_sample();
    in_t s;
    case ($urandom_range(0, 3))
      0: begin
        s.raw_temperature = 24'($urandom());
        s.raw_pressure = 24'($urandom());
      end
      default: begin
        s.raw_temperature = 24'($signed($urandom_range(0, 400000)) - 200000);
        s.raw_pressure = 24'($signed($urandom_range(0, 2000000)) - 1000000);
      end
    endcase
    return s;
  endfunction

  task automatic push_directed();
    logic signed [23:0] ext[6];
    ext = '{24'sh800000, 24'sh7FFFFF, 24'sd0, -24'sd1, 24'sd1, 24'sh555555};
    foreach (ext[i])
      foreach (ext[j])
        if ((i + j) % 2 == 0 || i == j) sample_queue.push_back('{ext[i], ext[j]});
  endtask

  task automatic run_phase(int n);
    repeat (n) sample_queue.push_back(rand_sample());
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    cal_lo = '0; cal_mid = '0; cal_hi = '0;
    @(posedge clk);

    // all-zero calibration from reset
    push_directed();
    wait_idle();

    load_typical();
    write_cal(CFG_UNUSED, rand64());   // dropped write
    push_directed();
    wait_idle();

    // extremes: mostly most negative, then most positive, then all-ones coefficients
    write_cal(CFG_CAL_0_7, 64'h8008_0000_8000_0800 & 64'h800800008000_0000 | 64'h0000_0000_0008_0000);
    write_cal(CFG_CAL_8_15, 64'h8000_8000_8000_8000);
    write_cal(CFG_CAL_16_20, 64'hFFFF_FF80_0800_800);
    run_phase(40);
    write_cal(CFG_CAL_0_7, 64'h7FF7_FF7F_FFF7_FFFF);
    write_cal(CFG_CAL_8_15, 64'h7FFF_7FFF_7FFF_7FFF);
    write_cal(CFG_CAL_16_20, 64'h0000_007F_FF7F_F7FF);
    run_phase(40);
    write_cal(CFG_CAL_0_7, '1);
    write_cal(CFG_CAL_8_15, '1);
    write_cal(CFG_CAL_16_20, '1);
    run_phase(40);

    // pressure: long receiver stall with the sender still offering
    load_typical();
    recv_holdoff = 200;
    run_phase(150);

    // random calibration sets
    repeat (4) begin
      write_cal(CFG_CAL_0_7, rand64());
      write_cal(CFG_CAL_8_15, rand64());
      write_cal(CFG_CAL_16_20, rand64());
      run_phase(80);
    end

    // sender pauses until everything is back, then resumes
    load_typical();
    repeat (30) sample_queue.push_back(rand_sample());
    repeat (20) @(posedge clk);
    send_drain = 1'b1;
    while (in_valid || compensated_queue.size() > 0) @(posedge clk);
    send_drain = 1'b0;
    run_phase(380);

    if (mismatch_count == 0 && compensated_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
